/* hdl/dense_set_swap_remove_defines.svh */
// Assertion macros for the dense set block.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef DENSE_SET_SWAP_REMOVE_DEFINES_SVH
`define DENSE_SET_SWAP_REMOVE_DEFINES_SVH

// Condition holds on every clock edge out of reset.
`define DSSR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define DSSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DSSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/dssr_pkg.sv */
// Shared constants and types for the dense set with swap-remove.
// No dependencies; used by dssr_cell, dssr_ctrl and the top level.
package dssr_pkg;

  localparam int CAPACITY_SLOTS_DEF = 1024;

  localparam int CMD_W      = 2;
  localparam int VALUE_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int OUT_W      = 10;
  localparam int OUT_DATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Control flags of the search wave travelling down the cell chain.
  typedef struct packed {
    logic active;
    logic zone;   // wave has passed the last filled slot
    logic found;
  } wave_flags_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    count;
    logic [OUT_W-1:0]    slot;
  } result_t;

endpackage

/* hdl/dssr_cell.sv */
// One slot of the list: holds an entry and passes the search wave down.
// Depends on dssr_pkg.
module dssr_cell #(
  parameter int IDX_W    = 10,
  parameter int CELL_IDX = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic [IDX_W-1:0]          wr_val,
  input  logic [IDX_W-1:0]          key,
  input  logic [IDX_W-1:0]          count,
  input  dssr_pkg::wave_flags_t     flags_in,
  input  logic [IDX_W-1:0]          last_in,
  input  logic [IDX_W-1:0]          slot_in,
  output dssr_pkg::wave_flags_t     flags_out,
  output logic [IDX_W-1:0]          last_out,
  output logic [IDX_W-1:0]          slot_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [IDX_W-1:0]      data_r, data_nxt;
  dssr_pkg::wave_flags_t flags_r, flags_nxt;
  logic [IDX_W-1:0]      last_r, last_nxt;
  logic [IDX_W-1:0]      slot_r, slot_nxt;
  logic                  is_top;
  logic                  hit;

  always_comb begin
    is_top   = (count == MY_IDX);
    last_nxt = is_top ? data_r : last_in;
    hit      = flags_in.active && (flags_in.zone || is_top) && !flags_in.found &&
               (data_r == key);

    flags_nxt.active = flags_in.active;
    flags_nxt.zone   = flags_in.zone || is_top;
    flags_nxt.found  = flags_in.found || hit;
    slot_nxt         = hit ? MY_IDX : slot_in;

    // take the last entry into the freed slot
    data_nxt = data_r;
    if (wr_en && (wr_idx == MY_IDX)) begin
      data_nxt = wr_val;
    end else if (hit) begin
      data_nxt = last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
    data_r <= data_nxt;
    last_r <= last_nxt;
    slot_r <= slot_nxt;
  end

  assign flags_out = flags_r;
  assign last_out  = last_r;
  assign slot_out  = slot_r;

endmodule

/* hdl/dssr_ctrl.sv */
// Command decode, entry count, search launch and result buffering.
// Depends on dssr_pkg and dense_set_swap_remove_defines.svh.
`include "dense_set_swap_remove_defines.svh"

module dssr_ctrl #(
  parameter  int CAPACITY_SLOTS = dssr_pkg::CAPACITY_SLOTS_DEF,
  localparam int IDX_W          = $clog2(CAPACITY_SLOTS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dssr_pkg::VALUE_W-1:0]    in_tdata,
  input  logic [dssr_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dssr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [dssr_pkg::STATUS_W-1:0]   out_tuser,
  output logic                            wr_en,
  output logic [IDX_W-1:0]                wr_idx,
  output logic [IDX_W-1:0]                wr_val,
  output logic [IDX_W-1:0]                key,
  output logic [IDX_W-1:0]                count,
  output dssr_pkg::wave_flags_t           top_flags,
  input  dssr_pkg::wave_flags_t           ret_flags,
  input  logic [IDX_W-1:0]                ret_slot
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY_SLOTS - 1);

  typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      key_r, key_nxt;
  logic                  top_active_r, top_active_nxt;
  logic                  wr_en_r, wr_en_nxt;
  logic [IDX_W-1:0]      wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]      wr_val_r, wr_val_nxt;
  dssr_pkg::result_t     out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  dssr_pkg::result_t     res_r, res_nxt;
  logic                  res_valid_r, res_valid_nxt;

  logic                  acc;
  logic                  in_range;
  logic                  new_valid;
  logic [dssr_pkg::STATUS_W-1:0] new_status;
  logic [IDX_W-1:0]      new_slot;
  logic [IDX_W+9:0]      slot_ext;
  logic [IDX_W+9:0]      count_ext;
  dssr_pkg::result_t     new_res;
  logic                  out_free;

  assign in_tready = (state_r == ST_IDLE) && !res_valid_r;
  assign acc       = in_tvalid && in_tready;
  assign in_range  = !in_tdata[dssr_pkg::VALUE_W-1] &&
                     ({2'b00, in_tdata[dssr_pkg::VALUE_W-2:0]} < 17'(CAPACITY_SLOTS));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    top_active_nxt = 1'b0;
    wr_en_nxt      = 1'b0;
    wr_idx_nxt     = wr_idx_r;
    wr_val_nxt     = wr_val_r;
    new_valid      = 1'b0;
    new_status     = dssr_pkg::ST_DONE;
    new_slot       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          new_valid = 1'b1;
          unique case (in_tuser)
            dssr_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            dssr_pkg::CMD_ADD: begin
              if (!in_range) begin
                new_status = dssr_pkg::ST_RANGE;
              end else if (count_r == LAST_IDX) begin
                new_status = dssr_pkg::ST_FULL;
              end else begin
                count_nxt  = count_r + 1'b1;
                wr_en_nxt  = 1'b1;
                wr_idx_nxt = count_r + 1'b1;
                wr_val_nxt = in_tdata[IDX_W-1:0];
                new_slot   = count_r + 1'b1;
              end
            end
            dssr_pkg::CMD_REMOVE: begin
              if (!in_range) begin
                new_status = dssr_pkg::ST_RANGE;
              end else begin
                // launch the wave at the top cell; result comes at the bottom
                new_valid      = 1'b0;
                key_nxt        = in_tdata[IDX_W-1:0];
                top_active_nxt = 1'b1;
                state_nxt      = ST_SEARCH;
              end
            end
            default: begin
              new_status = dssr_pkg::ST_DONE;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (ret_flags.active) begin
          state_nxt = ST_IDLE;
          new_valid = 1'b1;
          if (ret_flags.found) begin
            count_nxt = count_r - 1'b1;
            new_slot  = ret_slot;
          end else begin
            new_status = dssr_pkg::ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    slot_ext       = {10'd0, new_slot};
    count_ext      = {10'd0, count_nxt};
    new_res.status = new_status;
    new_res.slot   = slot_ext[dssr_pkg::OUT_W-1:0];
    new_res.count  = count_ext[dssr_pkg::OUT_W-1:0];

    // output register with one skid entry behind it
    out_free      = !out_valid_r || out_tready;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    if (out_free) begin
      if (res_valid_r) begin
        out_nxt       = res_r;
        out_valid_nxt = 1'b1;
        res_nxt       = new_res;
        res_valid_nxt = new_valid;
      end else begin
        out_nxt       = new_res;
        out_valid_nxt = new_valid;
      end
    end else if (new_valid) begin
      res_nxt       = new_res;
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      top_active_r <= 1'b0;
      wr_en_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      top_active_r <= top_active_nxt;
      wr_en_r      <= wr_en_nxt;
      out_valid_r  <= out_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
    key_r    <= key_nxt;
    wr_idx_r <= wr_idx_nxt;
    wr_val_r <= wr_val_nxt;
    out_r    <= out_nxt;
    res_r    <= res_nxt;
  end

  assign wr_en            = wr_en_r;
  assign wr_idx           = wr_idx_r;
  assign wr_val           = wr_val_r;
  assign key              = key_r;
  assign count            = count_r;
  assign top_flags.active = top_active_r;
  assign top_flags.zone   = 1'b0;
  assign top_flags.found  = 1'b0;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {4'd0, out_r.count, out_r.slot};

  `DSSR_ASSERT_IMPL(a_ret_in_search, ret_flags.active, state_r == ST_SEARCH, "wave returned outside a search")
  `DSSR_ASSERT_IMPL(a_skid_behind_out, res_valid_r, out_valid_r, "skid entry held with output empty")
  `DSSR_ASSERT_NEXT(a_launch_single, top_active_r, !top_active_r, "search launched twice")
  `DSSR_ASSERT_ALWAYS(a_count_bound, count_r <= LAST_IDX, "entry count beyond capacity")

endmodule

/* hdl/dense_set_swap_remove.sv */
// Dense unordered set with swap-remove, built as a chain of slot cells.
// Add, clear, unused and out-of-range commands: the result is registered at accept, in the output or skid register.
// Remove: a search wave walks the CAPACITY_SLOTS-1 cells one per cycle, from the top cell down
// to cell 1, and the result is registered when the wave returns to the controller.
// Throughput: 1 item/cycle while not searching; no item is taken during a remove, and a full skid stalls input.
// Reset (rst_n low, synchronous) empties the list; slot contents are not cleared.
module dense_set_swap_remove #(
  parameter int CAPACITY_SLOTS = dssr_pkg::CAPACITY_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dssr_pkg::VALUE_W-1:0]    in_tdata,   // [15:0] value
  input  logic [dssr_pkg::CMD_W-1:0]      in_tuser,   // [1:0] cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dssr_pkg::OUT_DATA_W-1:0] out_tdata,  // [9:0] slot, [19:10] count, [23:20] zero
  output logic [dssr_pkg::STATUS_W-1:0]   out_tuser   // [1:0] status
);

  localparam int IDX_W = $clog2(CAPACITY_SLOTS);

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      wr_val;
  logic [IDX_W-1:0]      key;
  logic [IDX_W-1:0]      count;
  dssr_pkg::wave_flags_t top_flags;

  dssr_pkg::wave_flags_t flags_c [1:CAPACITY_SLOTS-1];
  logic [IDX_W-1:0]      last_c  [1:CAPACITY_SLOTS-1];
  logic [IDX_W-1:0]      slot_c  [1:CAPACITY_SLOTS-1];

  dssr_ctrl #(
    .CAPACITY_SLOTS (CAPACITY_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .wr_en      (wr_en),
    .wr_idx     (wr_idx),
    .wr_val     (wr_val),
    .key        (key),
    .count      (count),
    .top_flags  (top_flags),
    .ret_flags  (flags_c[1]),
    .ret_slot   (slot_c[1])
  );

  // cell k takes the wave from cell k+1; the top cell takes it from the controller
  for (genvar k = 1; k < CAPACITY_SLOTS; k++) begin : g_cell
    if (k == CAPACITY_SLOTS - 1) begin : g_top
      dssr_cell #(
        .IDX_W    (IDX_W),
        .CELL_IDX (k)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_val    (wr_val),
        .key       (key),
        .count     (count),
        .flags_in  (top_flags),
        .last_in   ('0),
        .slot_in   ('0),
        .flags_out (flags_c[k]),
        .last_out  (last_c[k]),
        .slot_out  (slot_c[k])
      );
    end else begin : g_mid
      dssr_cell #(
        .IDX_W    (IDX_W),
        .CELL_IDX (k)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_val    (wr_val),
        .key       (key),
        .count     (count),
        .flags_in  (flags_c[k+1]),
        .last_in   (last_c[k+1]),
        .slot_in   (slot_c[k+1]),
        .flags_out (flags_c[k]),
        .last_out  (last_c[k]),
        .slot_out  (slot_c[k])
      );
    end
  end

endmodule

/* tb/tb.sv */
// Self-checking bench for dense_set_swap_remove: adds, swap-removes, clears and rejects.
// Depends on dssr_pkg and the block itself; a built-in predictor supplies the expected results, except for fixed rows.
`timescale 1ns / 100ps

module tb;
  import dssr_pkg::*;

  localparam int SLOTS = CAPACITY_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 580;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic               fixed;
    result_t            want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [VALUE_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  // Mirror of the list contents, slots 1..mirror_count
  logic [OUT_W-1:0] mirror_slots [SLOTS];
  int unsigned mirror_count = 0;

  result_t pending_results [$];
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned sent_count = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned cmd_seen [4] = '{0, 0, 0, 0};
  bit calm = 1'b0;

  // Fixed expectations as status, count, slot
  stim_row_t directed_rows [24] = '{
    '{CMD_REMOVE, 16'd5,     1'b1, '{ST_NOTFOUND, 10'd0, 10'd0}},
    '{CMD_ADD,    16'hFFFF,  1'b1, '{ST_RANGE,    10'd0, 10'd0}},
    '{CMD_ADD,    16'h8000,  1'b1, '{ST_RANGE,    10'd0, 10'd0}},
    '{CMD_ADD,    16'd1024,  1'b1, '{ST_RANGE,    10'd0, 10'd0}},
    '{CMD_REMOVE, 16'h7FFF,  1'b1, '{ST_RANGE,    10'd0, 10'd0}},
    '{CMD_ADD,    16'd0,     1'b1, '{ST_DONE,     10'd1, 10'd1}},
    '{CMD_ADD,    16'd1023,  1'b1, '{ST_DONE,     10'd2, 10'd2}},
    '{CMD_ADD,    16'd7,     1'b0, '0},
    '{CMD_ADD,    16'd7,     1'b0, '0},
    '{CMD_ADD,    16'd300,   1'b0, '0},
    '{CMD_UNUSED, 16'h5A5A,  1'b1, '{ST_DONE,     10'd5, 10'd0}},
    '{CMD_REMOVE, 16'd7,     1'b0, '0},
    '{CMD_REMOVE, 16'd300,   1'b0, '0},
    '{CMD_REMOVE, 16'd0,     1'b0, '0},
    '{CMD_REMOVE, 16'd1023,  1'b0, '0},
    '{CMD_REMOVE, 16'd1023,  1'b1, '{ST_NOTFOUND, 10'd1, 10'd0}},
    '{CMD_REMOVE, 16'd7,     1'b0, '0},
    '{CMD_ADD,    16'd512,   1'b0, '0},
    '{CMD_CLEAR,  16'hFFFF,  1'b1, '{ST_DONE,     10'd0, 10'd0}},
    '{CMD_REMOVE, 16'd512,   1'b1, '{ST_NOTFOUND, 10'd0, 10'd0}},
    '{CMD_UNUSED, 16'hFFFF,  1'b1, '{ST_DONE,     10'd0, 10'd0}},
    '{CMD_ADD,    16'h03FF,  1'b0, '0},
    '{CMD_REMOVE, 16'hFC00,  1'b1, '{ST_RANGE,    10'd1, 10'd0}},
    '{CMD_CLEAR,  16'd0,     1'b1, '{ST_DONE,     10'd0, 10'd0}}
  };

  dense_set_swap_remove i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, some short, a few long; none at all in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the mirrored list by one command and return the result it yields
  function automatic result_t apply_command(input logic [CMD_W-1:0] cmd,
                                            input logic [VALUE_W-1:0] value);
    result_t r;
    int v;
    int unsigned hit;
    r = '0;
    v = int'($signed(value));
    if (cmd == CMD_CLEAR) begin
      mirror_count = 0;
    end else if (cmd == CMD_ADD || cmd == CMD_REMOVE) begin
      if (v < 0 || v >= SLOTS) begin
        r.status = ST_RANGE;
      end else if (cmd == CMD_ADD) begin
        if (mirror_count + 1 >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          mirror_count++;
          mirror_slots[mirror_count] = v[OUT_W-1:0];
          r.slot = mirror_count[OUT_W-1:0];
        end
      end else begin
        // search from the top slot down, then move the last entry into the hole
        hit = mirror_count;
        while (hit != 0 && int'(mirror_slots[hit]) != v) hit--;
        if (hit == 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          mirror_slots[hit] = mirror_slots[mirror_count];
          mirror_count--;
          r.slot = hit[OUT_W-1:0];
        end
      end
    end
    r.count = mirror_count[OUT_W-1:0];
    return r;
  endfunction

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                       input bit fixed, input result_t want);
    int unsigned gap;
    result_t calc;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    calc = apply_command(cmd, value);
    if (fixed) calc = want;
    pending_results.push_back(calc);
    sent_count++;
    cmd_seen[cmd]++;
    status_seen[calc.status]++;
  endtask

  // Hold the input until every outstanding item has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value_in_range();
    if ($urandom_range(9) < 4) return VALUE_W'($urandom_range(0, 15));
    return VALUE_W'($urandom_range(0, SLOTS - 1));
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.slot = out_tdata[OUT_W-1:0];
      got.count = out_tdata[2*OUT_W-1:OUT_W];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: status %0d slot %0d count %0d",
                   got.status, got.slot, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got != want || out_tdata[OUT_DATA_W-1:2*OUT_W] != '0) begin
          error_count++;
          if (error_count <= 10)
            $display("result %0d: expected status %0d slot %0d count %0d, got status %0d slot %0d count %0d pad %h",
                     checked_count, want.status, want.slot, want.count,
                     got.status, got.slot, got.count, out_tdata[OUT_DATA_W-1:2*OUT_W]);
        end
        checked_count++;
      end
    end
  end

  initial begin
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned r;
    logic [CMD_W-1:0] cmd;
    logic [VALUE_W-1:0] value;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k])
      issue(directed_rows[k].cmd, directed_rows[k].value, directed_rows[k].fixed,
            directed_rows[k].want);
    settle();

    // Fill to capacity, then work the full list from both ends
    while (mirror_count < SLOTS - 1)
      issue(CMD_ADD, VALUE_W'($urandom_range(0, SLOTS - 2)), 1'b0, '0);
    issue(CMD_ADD, 16'd5, 1'b0, '0);
    issue(CMD_ADD, 16'd1022, 1'b0, '0);
    issue(CMD_ADD, 16'hFFFF, 1'b0, '0);
    issue(CMD_REMOVE, VALUE_W'(SLOTS - 1), 1'b0, '0);
    issue(CMD_REMOVE, {6'd0, mirror_slots[mirror_count]}, 1'b0, '0);
    issue(CMD_ADD, VALUE_W'(SLOTS - 1), 1'b0, '0);
    issue(CMD_ADD, 16'd9, 1'b0, '0);
    issue(CMD_REMOVE, VALUE_W'(SLOTS - 1), 1'b0, '0);
    issue(CMD_REMOVE, {6'd0, mirror_slots[1]}, 1'b0, '0);
    issue(CMD_CLEAR, 16'h1234, 1'b0, '0);
    settle();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(3) == 0);
      if (n % 90 == 89) settle();
      r = $urandom_range(99);
      if (r < 3) begin
        cmd = CMD_CLEAR;
        value = VALUE_W'($urandom);
      end else if (r < 6) begin
        cmd = CMD_UNUSED;
        value = VALUE_W'($urandom);
      end else if (r < 12) begin
        cmd = ($urandom_range(1) == 0) ? CMD_ADD : CMD_REMOVE;
        value = VALUE_W'($urandom_range(SLOTS, 65535));
      end else if (r < (mirror_count > 48 ? 40 : 55)) begin
        cmd = CMD_ADD;
        value = pick_value_in_range();
      end else begin
        cmd = CMD_REMOVE;
        if (mirror_count != 0 && $urandom_range(3) != 0)
          value = {6'd0, mirror_slots[$urandom_range(1, mirror_count)]};
        else
          value = pick_value_in_range();
      end
      issue(cmd, value, 1'b0, '0);
    end

    settle();
    repeat (SLOTS + 16) @(posedge clk);
    $display("%0d items sent (%0d add, %0d remove, %0d clear, %0d unused), %0d results checked",
             sent_count, cmd_seen[CMD_ADD], cmd_seen[CMD_REMOVE], cmd_seen[CMD_CLEAR],
             cmd_seen[CMD_UNUSED], checked_count);
    $display("statuses: %0d done, %0d out of range, %0d full, %0d not found; %0d mismatches",
             status_seen[ST_DONE], status_seen[ST_RANGE], status_seen[ST_FULL],
             status_seen[ST_NOTFOUND], error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
